/* hdl/msr_pkg.sv */
// Shared constants of the seven-point restriction core.
// No dependencies; imported by the top level, the divide-by-three unit and the bench.
package msr_pkg;

   // Field widths fixed by the interface.
   localparam int POS_W   = 6;
   localparam int COORD_W = 7;
   localparam int CFG_W   = 6;

   // Reset value of the fine size register.
   localparam logic [CFG_W-1:0] FINE_SIZE_RESET = 6'd33;

   // Command codes.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Rounding bias added before the divide by twelve (half of twelve).
   localparam int ROUND_BIAS = 6;

   // The divide by twelve is a shift by two followed by a divide by three.
   // The divide by three takes sixteen quotient bits at a time by multiplying
   // with the reciprocal of three, rounded up, and shifting right.
   localparam int DIVISOR     = 3;
   localparam int DIGIT_BITS  = 16;
   localparam int RECIP_SHIFT = DIGIT_BITS + 3;
   localparam int RECIP       = (2 ** RECIP_SHIFT + DIVISOR - 1) / DIVISOR;

endpackage

/* hdl/msr_ram.sv */
// Generic single-port RAM with a registered read port.
// No dependencies; used for the fine grid sample store.
module msr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One access per cycle: a write, or a read whose data shows up next cycle.
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[addr] <= wdata;
      end else begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/msr_div3.sv */
// Unsigned divide by three, sixteen quotient bits per cycle by reciprocal multiplication.
// Depends on msr_pkg for the divisor, the digit size and the reciprocal.
module msr_div3
   import msr_pkg::*;
#(
   parameter int WIDTH = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);

   localparam int NDIG  = (WIDTH + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int PW    = NDIG * DIGIT_BITS;
   localparam int CNT_W = $clog2(NDIG + 1);
   localparam int TW    = DIGIT_BITS + 2;
   localparam int PRW   = 2 * TW;
   localparam logic [TW-1:0] RECIP_T = TW'(RECIP);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [PW-1:0]         shift_ff, shift_in;
   logic [PW-1:0]         quot_ff, quot_in;
   logic [1:0]            rem_ff, rem_in;
   logic [DIGIT_BITS-1:0] digit;

   // One quotient digit per cycle: the carried remainder above the next digit
   // is divided by multiplying with the reciprocal, then the new remainder is
   // what is left after taking away three times the digit.
   always_comb begin
      logic [TW-1:0]  trial;
      logic [PRW-1:0] product;
      trial   = {rem_ff, shift_ff[PW-1 -: DIGIT_BITS]};
      product = PRW'(trial) * PRW'(RECIP_T);
      digit   = product[RECIP_SHIFT +: DIGIT_BITS];
      rem_in  = 2'(trial - TW'(digit) * TW'(DIVISOR));
   end

   // Sequencing: load on start, then one digit per cycle until all are done.
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      shift_in = shift_ff;
      quot_in  = quot_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         shift_in = PW'(dividend);
         quot_in  = '0;
      end else if (busy_ff) begin
         shift_in = {shift_ff[PW-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
         quot_in  = {quot_ff[PW-DIGIT_BITS-1:0], digit};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(NDIG - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      shift_ff <= shift_in;
      quot_ff  <= quot_in;
      rem_ff   <= start ? 2'b00 : (busy_ff ? rem_in : rem_ff);
   end

   assign done     = done_ff;
   assign quotient = quot_ff[WIDTH-1:0];

endmodule

/* hdl/multigrid_seven_point_restriction_core.sv */
// Top level of the seven-point multigrid restriction core.
// Depends on msr_pkg, msr_ram (fine grid store) and msr_div3 (divide unit).
//
//   channel   direction  signals                                  word
//   req       in         req_valid/req_ready                      command, x, y, z, sample
//   rsp       out        rsp_valid/rsp_ready                      coarse value, error flag
//   csr       in         csr_valid/csr_ready                      fine size
//
// A write word inside the grid goes straight into the grid RAM.
// A query runs seven reads through the single RAM port, a drain state, a setup state,
// the divide by three at sixteen bits a cycle and the load of the result register.
// A query outside the interior skips to the completion state. A waiting
// result does not block writes; a finished query waits for the result register to free up.
// Reset clears only control state and the fine size register; the grid holds garbage until written.
module multigrid_seven_point_restriction_core
   import msr_pkg::*;
#(
   parameter int MAX_FINE_SIZE = 33,
   parameter int SAMPLE_WIDTH  = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_command,
   input  logic [POS_W-1:0]        req_pos_x,
   input  logic [POS_W-1:0]        req_pos_y,
   input  logic [POS_W-1:0]        req_pos_z,
   input  logic [SAMPLE_WIDTH-1:0] req_sample_in,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [SAMPLE_WIDTH-1:0] rsp_coarse_value,
   output logic                    rsp_query_error,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CFG_W-1:0]        csr_wdata
);

   localparam int DEPTH  = MAX_FINE_SIZE * MAX_FINE_SIZE * MAX_FINE_SIZE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int AW     = SAMPLE_WIDTH + 4;
   localparam int DW     = SAMPLE_WIDTH + 1;
   localparam logic [ADDR_W-1:0] M_A   = ADDR_W'(MAX_FINE_SIZE);
   localparam logic [7:0]        MAX_N = 8'(MAX_FINE_SIZE);

   // Neighbor read order.
   localparam logic [2:0] NB_CENTRE = 3'd0;
   localparam logic [2:0] NB_XP     = 3'd1;
   localparam logic [2:0] NB_XM     = 3'd2;
   localparam logic [2:0] NB_YP     = 3'd3;
   localparam logic [2:0] NB_YM     = 3'd4;
   localparam logic [2:0] NB_ZP     = 3'd5;
   localparam logic [2:0] NB_LAST   = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_SETUP,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [2:0]                nb_sel_ff, nb_sel_in;
   logic                      rd_valid_ff, rd_valid_in;
   logic                      rd_centre_ff, rd_centre_in;
   logic [COORD_W-1:0]        cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [AW-1:0]             acc_ff, acc_in;
   logic                      neg_ff, neg_in;
   logic                      err_ff, err_in;
   logic [SAMPLE_WIDTH-1:0]   result_ff, result_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0]   rsp_value_ff, rsp_value_in;
   logic                      rsp_err_ff, rsp_err_in;
   logic [CFG_W-1:0]          fine_size_ff;

   logic                      req_fire;
   logic [7:0]                eff_n, coarse_n, coarse_hi;
   logic                      wr_in_range, in_interior;
   logic                      ram_we;
   logic [ADDR_W-1:0]         ram_addr, wr_addr, nb_addr;
   logic [SAMPLE_WIDTH-1:0]   ram_rdata;
   logic [AW-1:0]             ext, weighted, mag;
   logic                      div_start, div_done;
   logic [DW-1:0]             div_quot;

   function automatic logic [ADDR_W-1:0] fine_addr(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y,
                                                   input logic [COORD_W-1:0] z);
      logic [ADDR_W-1:0] row;
      row = ADDR_W'(ADDR_W'(x) * M_A + ADDR_W'(y));
      return ADDR_W'(row * M_A + ADDR_W'(z));
   endfunction

   // Configuration register; the user must write it only while the core is idle, the block does not enforce it.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fine_size_ff <= FINE_SIZE_RESET;
      end else if (csr_valid) begin
         fine_size_ff <= csr_wdata;
      end
   end

   // Effective grid size, write range check and coarse interior check.
   assign eff_n       = ({2'b00, fine_size_ff} > MAX_N) ? MAX_N : {2'b00, fine_size_ff};
   assign coarse_n    = 8'((eff_n + 8'd1) >> 1);
   assign coarse_hi   = coarse_n - 8'd2;
   assign wr_in_range = ({2'b00, req_pos_x} < eff_n) && ({2'b00, req_pos_y} < eff_n) &&
                        ({2'b00, req_pos_z} < eff_n);
   assign in_interior = (coarse_n >= 8'd3) &&
                        (req_pos_x != '0) && ({2'b00, req_pos_x} <= coarse_hi) &&
                        (req_pos_y != '0) && ({2'b00, req_pos_y} <= coarse_hi) &&
                        (req_pos_z != '0) && ({2'b00, req_pos_z} <= coarse_hi);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // RAM port: writes from the request word, reads from the neighbor sequencer.
   assign wr_addr = fine_addr({1'b0, req_pos_x}, {1'b0, req_pos_y}, {1'b0, req_pos_z});
   assign ram_we  = req_fire && (req_command == CMD_WRITE) && wr_in_range;

   always_comb begin
      unique case (nb_sel_ff)
         NB_CENTRE: nb_addr = fine_addr(cx_ff, cy_ff, cz_ff);
         NB_XP:     nb_addr = fine_addr(cx_ff + 1'b1, cy_ff, cz_ff);
         NB_XM:     nb_addr = fine_addr(cx_ff - 1'b1, cy_ff, cz_ff);
         NB_YP:     nb_addr = fine_addr(cx_ff, cy_ff + 1'b1, cz_ff);
         NB_YM:     nb_addr = fine_addr(cx_ff, cy_ff - 1'b1, cz_ff);
         NB_ZP:     nb_addr = fine_addr(cx_ff, cy_ff, cz_ff + 1'b1);
         NB_LAST:   nb_addr = fine_addr(cx_ff, cy_ff, cz_ff - 1'b1);
         default:   nb_addr = fine_addr(cx_ff, cy_ff, cz_ff);
      endcase
   end

   assign ram_addr = (state_ff == ST_READ) ? nb_addr : wr_addr;

   msr_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock    (clock),
      .write_en (ram_we),
      .addr     (ram_addr),
      .wdata    (req_sample_in),
      .rdata    (ram_rdata)
   );

   // The centre sample carries weight six, the face neighbors weight one.
   assign ext      = {{4{ram_rdata[SAMPLE_WIDTH-1]}}, ram_rdata};
   assign weighted = rd_centre_ff ? ({ext[AW-3:0], 2'b00} + {ext[AW-2:0], 1'b0}) : ext;

   // Floor division of a negative sum uses the one's complement identity,
   // and the divide by twelve becomes a shift by two and a divide by three.
   assign mag       = acc_ff[AW-1] ? ~acc_ff : acc_ff;
   assign div_start = (state_ff == ST_SETUP);

   msr_div3 #(
      .WIDTH (DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag[AW-2:2]),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Query sequencer and result register.
   always_comb begin
      state_in     = state_ff;
      nb_sel_in    = nb_sel_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      err_in       = err_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;
      rd_valid_in  = (state_ff == ST_READ);
      rd_centre_in = (nb_sel_ff == NB_CENTRE);

      if (rd_valid_ff) begin
         acc_in = acc_ff + weighted;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_command == CMD_QUERY)) begin
               cx_in     = {req_pos_x, 1'b0};
               cy_in     = {req_pos_y, 1'b0};
               cz_in     = {req_pos_z, 1'b0};
               acc_in    = AW'(ROUND_BIAS);
               nb_sel_in = NB_CENTRE;
               err_in    = !in_interior;
               state_in  = in_interior ? ST_READ : ST_DONE;
            end
         end
         ST_READ: begin
            nb_sel_in = nb_sel_ff + 1'b1;
            if (nb_sel_ff == NB_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            neg_in   = acc_ff[AW-1];
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               result_in = neg_ff ? ~div_quot[SAMPLE_WIDTH-1:0] : div_quot[SAMPLE_WIDTH-1:0];
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = err_ff ? '0 : result_ff;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         nb_sel_ff    <= NB_CENTRE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= rd_valid_in;
         nb_sel_ff    <= nb_sel_in;
      end
      rd_centre_ff <= rd_centre_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      cz_ff        <= cz_in;
      acc_ff       <= acc_in;
      neg_ff       <= neg_in;
      err_ff       <= err_in;
      result_ff    <= result_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_coarse_value = rsp_value_ff;
   assign rsp_query_error  = rsp_err_ff;

   // The grid is written only while no query owns the RAM port.
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_IDLE))
      else $error("grid write while a query is in progress");

   // The divider finishes only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide phase");

   // A new result appears only from the completion state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised without a finished query");

   // Neighbor data is accumulated only during the read and drain phases.
   assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> ((state_ff == ST_READ) || (state_ff == ST_DRAIN)))
      else $error("stray RAM read data in accumulator");

endmodule

/* bench/multigrid_seven_point_restriction_core_test.sv */
// Self-checking bench for the seven-point multigrid restriction core.
// Depends on msr_pkg and multigrid_seven_point_restriction_core; it predicts every
// coarse result from its own copy of the fine grid and checks each response word.
`timescale 1ns / 1ps

module multigrid_seven_point_restriction_core_test
   import msr_pkg::*;
();

   localparam int GRID_N       = 33;
   localparam int SAMPLE_W     = 32;
   localparam int GRID_CELLS   = GRID_N * GRID_N * GRID_N;
   localparam int QUIET_CYCLES = 20;
   localparam int STALL_LIMIT  = 4000;
   localparam int REPORT_LIMIT = 10;
   localparam int IDLE_PCT     = 16;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [SAMPLE_W-1:0] coarse_value;
      logic                query_error;
   } coarse_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_command = CMD_WRITE;
   logic [POS_W-1:0]    req_pos_x = '0;
   logic [POS_W-1:0]    req_pos_y = '0;
   logic [POS_W-1:0]    req_pos_z = '0;
   logic [SAMPLE_W-1:0] req_sample_in = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [SAMPLE_W-1:0] rsp_coarse_value;
   logic                rsp_query_error;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CFG_W-1:0]    csr_wdata = '0;

   // Shadow of the fine grid and of the size register, plus the results still owed.
   logic signed [SAMPLE_W-1:0] fine_copy [GRID_CELLS];
   bit                         fine_written [GRID_CELLS];
   logic [CFG_W-1:0]           fine_size_copy = FINE_SIZE_RESET;
   coarse_result_type          coarse_results_due [$];
   coarse_result_type          due_result;

   int mismatch_count = 0;
   int useful_words   = 0;
   int stall_cycles   = 0;
   int sink_hold_left = 0;
   bit sender_steady  = 1'b0;
   bit sink_steady    = 1'b0;

   multigrid_seven_point_restriction_core #(
      .MAX_FINE_SIZE(GRID_N),
      .SAMPLE_WIDTH (SAMPLE_W)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_sample_in   (req_sample_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_coarse_value(rsp_coarse_value),
      .rsp_query_error (rsp_query_error),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata)
   );

   always #6 clock = ~clock;

   // Sizes as the core sees them: register values above the grid clamp to it.
   function automatic int effective_size();
      return (fine_size_copy > GRID_N) ? GRID_N : int'(fine_size_copy);
   endfunction

   function automatic int coarse_size();
      return (effective_size() + 1) / 2;
   endfunction

   function automatic bit coarse_interior(int ci, int cj, int ck);
      int cs;
      cs = coarse_size();
      return cs >= 3 && ci >= 1 && ci <= cs - 2 && cj >= 1 && cj <= cs - 2
             && ck >= 1 && ck <= cs - 2;
   endfunction

   function automatic int grid_slot(int x, int y, int z);
      return (x * GRID_N + y) * GRID_N + z;
   endfunction

   // Point k of the stencil: 0 is the centre, 1..6 the face neighbors.
   function automatic void face_point(int ci, int cj, int ck, int k,
                                      output int x, output int y, output int z);
      x = 2 * ci;
      y = 2 * cj;
      z = 2 * ck;
      case (k)
         1: x = x + 1;
         2: x = x - 1;
         3: y = y + 1;
         4: y = y - 1;
         5: z = z + 1;
         6: z = z - 1;
         default: ;
      endcase
   endfunction

   // Weighted stencil sum over twelve, rounded half up, or the error flag.
   function automatic coarse_result_type restrict_coarse(int ci, int cj, int ck);
      coarse_result_type res;
      longint            total;
      longint            quotient;
      int                x, y, z;
      res.coarse_value = '0;
      res.query_error  = 1'b1;
      if (coarse_interior(ci, cj, ck)) begin
         total = 6;
         for (int k = 0; k < 7; k++) begin
            face_point(ci, cj, ck, k, x, y, z);
            total = total + (k == 0 ? 6 : 1) * longint'(fine_copy[grid_slot(x, y, z)]);
         end
         quotient = total / 12;
         if (total % 12 < 0) quotient = quotient - 1;
         res.coarse_value = quotient[SAMPLE_W-1:0];
         res.query_error  = 1'b0;
      end
      return res;
   endfunction

   // Applies one accepted word to the shadow grid or to the results owed.
   function automatic void commit_word(logic cmd, int x, int y, int z,
                                       logic [SAMPLE_W-1:0] sample);
      int n;
      n = effective_size();
      if (cmd == CMD_WRITE) begin
         if (x < n && y < n && z < n) begin
            fine_copy[grid_slot(x, y, z)]    = sample;
            fine_written[grid_slot(x, y, z)] = 1'b1;
            useful_words++;
         end
      end else begin
         coarse_results_due.push_back(restrict_coarse(x, y, z));
         useful_words++;
      end
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2, 3: return SAMPLE_W'($urandom_range(0, 24) - 12);
         default: return $urandom();
      endcase
   endfunction

   function automatic void note_mismatch(string what, logic [SAMPLE_W-1:0] want,
                                         logic [SAMPLE_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: mismatch in %0s: expected %h, got %h", $realtime, what, want, got);
   endfunction

   // Offers one request word at the falling edge and holds it until accepted.
   task automatic send_word(logic cmd, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                            logic [POS_W-1:0] z, logic [SAMPLE_W-1:0] sample);
      @(negedge clock);
      if (!sender_steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_pos_x     <= x;
      req_pos_y     <= y;
      req_pos_z     <= z;
      req_sample_in <= sample;
      do @(posedge clock); while (!req_ready);
      commit_word(cmd, x, y, z, sample);
   endtask

   // Writes the whole stencil of one coarse point.
   task automatic fill_neighborhood(int ci, int cj, int ck, logic [SAMPLE_W-1:0] centre,
                                    logic [SAMPLE_W-1:0] others);
      int x, y, z;
      for (int k = 0; k < 7; k++) begin
         face_point(ci, cj, ck, k, x, y, z);
         send_word(CMD_WRITE, POS_W'(x), POS_W'(y), POS_W'(z), k == 0 ? centre : others);
      end
   endtask

   // Queries a coarse point; for an interior point it first writes every stencil
   // sample not yet written, and rewrites others at random.
   task automatic query_point(int ci, int cj, int ck, int rewrite_pct);
      int x, y, z;
      if (coarse_interior(ci, cj, ck)) begin
         for (int k = 0; k < 7; k++) begin
            face_point(ci, cj, ck, k, x, y, z);
            if (!fine_written[grid_slot(x, y, z)] || $urandom_range(0, 99) < rewrite_pct)
               send_word(CMD_WRITE, POS_W'(x), POS_W'(y), POS_W'(z), pick_sample());
         end
      end
      send_word(CMD_QUERY, POS_W'(ci), POS_W'(cj), POS_W'(ck), $urandom());
   endtask

   // Drops the request valid and waits until every result is in and the core is idle.
   task automatic wait_until_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (coarse_results_due.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_fine_size(int value);
      wait_until_quiet();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= CFG_W'(value);
      do @(posedge clock); while (!csr_ready);
      fine_size_copy = CFG_W'(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random mix: mostly stencil fills followed by their query, the rest stray
   // writes, queries anywhere in the field range and queries on the rim.
   task automatic run_mixed_traffic(int budget);
      int stop_at, roll, cs, n, hi, rim, axis;
      int c [3];
      stop_at = useful_words + budget;
      while (useful_words < stop_at) begin
         cs   = coarse_size();
         n    = effective_size();
         hi   = (cs >= 3) ? cs - 2 : 1;
         roll = $urandom_range(0, 99);
         if (roll < 60 && cs >= 3) begin
            query_point($urandom_range(1, hi), $urandom_range(1, hi), $urandom_range(1, hi), 25);
         end else if (roll < 75) begin
            query_point($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63), 25);
         end else if (roll < 88) begin
            if (n > 0 && $urandom_range(0, 1) == 1)
               send_word(CMD_WRITE, POS_W'($urandom_range(0, n - 1)),
                         POS_W'($urandom_range(0, n - 1)), POS_W'($urandom_range(0, n - 1)),
                         pick_sample());
            else
               send_word(CMD_WRITE, POS_W'($urandom_range(0, 63)), POS_W'($urandom_range(0, 63)),
                         POS_W'($urandom_range(0, 63)), pick_sample());
         end else begin
            case ($urandom_range(0, 3))
               0: rim = 0;
               1: rim = (cs > 0) ? cs - 1 : 0;
               2: rim = cs;
               default: rim = 63;
            endcase
            for (int a = 0; a < 3; a++) c[a] = $urandom_range(1, hi);
            axis    = $urandom_range(0, 2);
            c[axis] = rim;
            query_point(c[0], c[1], c[2], 25);
         end
      end
   endtask

   // Field extremes, exact-half rounding, dropped writes and rejected queries.
   task automatic test_directed_extremes();
      fill_neighborhood(1, 1, 1, SAMPLE_MAX, SAMPLE_MAX);
      send_word(CMD_QUERY, 6'd1, 6'd1, 6'd1, '0);
      send_word(CMD_WRITE, 6'd2, 6'd2, 6'd2, SAMPLE_MIN);
      send_word(CMD_QUERY, 6'd1, 6'd1, 6'd1, SAMPLE_MAX);
      // A sum of minus six sits exactly halfway and must round up to zero.
      fill_neighborhood(15, 15, 15, '1, '0);
      send_word(CMD_QUERY, 6'd15, 6'd15, 6'd15, '1);
      send_word(CMD_WRITE, 6'd33, 6'd5, 6'd5, 32'h1234_5678);
      send_word(CMD_WRITE, 6'd63, 6'd63, 6'd63, '1);
      send_word(CMD_QUERY, 6'd0, 6'd1, 6'd1, '0);
      send_word(CMD_QUERY, 6'd16, 6'd1, 6'd1, '0);
      send_word(CMD_QUERY, 6'd1, 6'd1, 6'd63, '0);
      send_word(CMD_QUERY, 6'd63, 6'd63, 6'd63, '0);
   endtask

   // Smallest interior, even size, no interior at all, and sizes above the grid.
   // Samples written earlier must survive each resize.
   task automatic test_fine_size_settings();
      int sizes [7];
      sizes = '{5, 6, 4, 0, 63, 34, 7};
      foreach (sizes[i]) begin
         write_fine_size(sizes[i]);
         query_point(1, 1, 1, 0);
         run_mixed_traffic(25);
      end
   endtask

   // Bulk random traffic; the middle phase runs with no idling on either side.
   task automatic test_random_traffic();
      int sizes [5];
      sizes = '{33, 17, 63, 9, 33};
      foreach (sizes[i]) begin
         write_fine_size(sizes[i]);
         sender_steady = (i == 2);
         sink_steady   = (i == 2);
         run_mixed_traffic(170);
      end
      sender_steady = 1'b0;
      sink_steady   = 1'b0;
   endtask

   // The receiver holds off for a long stretch while queries keep coming, so the
   // result register fills and the core stops taking request words.
   task automatic test_result_backpressure();
      write_fine_size(GRID_N);
      for (int p = 0; p < 4; p++) query_point(2 + p, 3, 4 + p, 0);
      sender_steady  = 1'b1;
      sink_hold_left = 400;
      for (int r = 0; r < 24; r++) query_point(2 + r % 4, 3, 4 + r % 4, 20);
      sender_steady = 1'b0;
   endtask

   // Response side: a requested hold-off first, otherwise random or steady ready.
   always @(negedge clock) begin
      if (sink_hold_left > 0) begin
         rsp_ready <= 1'b0;
         sink_hold_left = sink_hold_left - 1;
      end else if (sink_steady) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Each accepted response word is checked against the oldest result owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (coarse_results_due.size() == 0) begin
            note_mismatch("response with no query pending", '0, rsp_coarse_value);
         end else begin
            due_result = coarse_results_due.pop_front();
            if (rsp_coarse_value !== due_result.coarse_value)
               note_mismatch("coarse value", due_result.coarse_value, rsp_coarse_value);
            if (rsp_query_error !== due_result.query_error)
               note_mismatch("error flag", SAMPLE_W'(due_result.query_error),
                             SAMPLE_W'(rsp_query_error));
         end
      end
   end

   // Watchdog: ends the run when no word moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles = stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_directed_extremes();
      test_fine_size_settings();
      test_random_traffic();
      test_result_backpressure();
      wait_until_quiet();
      if (mismatch_count == 0 && coarse_results_due.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
